// ----- sv/pcgb_pkg.sv -----
// pcgb_pkg: shared types, constants and the xsh-rr output function
// for the pcg32 bounded random block; no dependencies
`default_nettype none

package pcgb_pkg;

    localparam int unsigned STATE_W = 64;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned CNT_W   = 5;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned PDATA_W = 64;

    localparam logic [STATE_W-1:0] LCG_MULT = 64'd6364136223846793005;
    localparam logic [DATA_W-1:0]  MULT_LO  = LCG_MULT[31:0];
    localparam logic [DATA_W-1:0]  MULT_HI  = LCG_MULT[63:32];

    // register select is address bit 3 (registers sit at 8*i)
    localparam logic REG_SEED = 1'b0;
    localparam logic REG_INC  = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } ctrl_state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LOW,
        PH_MID_A,
        PH_MID_B
    } lcg_phase_t;

    typedef struct packed {
        logic div_busy;
        logic lcg_busy;
    } unit_status_t;

    typedef struct packed {
        logic start;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic               seed_we;
        logic               inc_we;
        logic [PDATA_W-1:0] wdata;
    } cfg_wr_t;

    function automatic logic [DATA_W-1:0] xsh_rr(input logic [STATE_W-1:0] s);
        logic [STATE_W-1:0]  mix_wide;
        logic [DATA_W-1:0]   mixed;
        logic [4:0]          amount;
        logic [2*DATA_W-1:0] doubled;
        mix_wide = ((s >> 18) ^ s) >> 27;
        mixed    = mix_wide[DATA_W-1:0];
        amount   = s[63:59];
        doubled  = {mixed, mixed} >> amount;
        return doubled[DATA_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- sv/pcgb_lcg.sv -----
// pcgb_lcg: seed/increment registers and the 64-bit state advance,
// done as three 32x32 partial products on one multiplier; uses pcgb_pkg
`default_nettype none

module pcgb_lcg (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire pcgb_pkg::cfg_wr_t           cfg,
    input  wire                              start,
    output logic                             busy,
    output logic [pcgb_pkg::STATE_W-1:0]     state,
    output logic [pcgb_pkg::STATE_W-1:0]     seed,
    output logic [pcgb_pkg::STATE_W-1:0]     incr
);

    pcgb_pkg::lcg_phase_t              phase_reg, phase_next;
    logic [pcgb_pkg::STATE_W-1:0]      seed_reg, seed_next;
    logic [pcgb_pkg::STATE_W-1:0]      inc_reg, inc_next;
    logic [pcgb_pkg::STATE_W-1:0]      state_reg, state_next;
    logic [pcgb_pkg::STATE_W-1:0]      old_reg, old_next;
    logic [pcgb_pkg::STATE_W-1:0]      acc_reg, acc_next;
    logic [pcgb_pkg::DATA_W-1:0]       mul_a, mul_b;
    logic [2*pcgb_pkg::DATA_W-1:0]     prod;

    // operand select for the shared multiplier
    always_comb begin
        case (phase_reg)
            pcgb_pkg::PH_LOW: begin
                mul_a = old_reg[31:0];
                mul_b = pcgb_pkg::MULT_LO;
            end
            pcgb_pkg::PH_MID_A: begin
                mul_a = old_reg[31:0];
                mul_b = pcgb_pkg::MULT_HI;
            end
            pcgb_pkg::PH_MID_B: begin
                mul_a = old_reg[63:32];
                mul_b = pcgb_pkg::MULT_LO;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb begin
        case (phase_reg)
            pcgb_pkg::PH_LOW:   acc_next = prod + {inc_reg[63:1], 1'b1};
            pcgb_pkg::PH_MID_A: acc_next = acc_reg + {prod[31:0], 32'd0};
            pcgb_pkg::PH_MID_B: acc_next = acc_reg + {prod[31:0], 32'd0};
            default:            acc_next = acc_reg;
        endcase
    end

    always_comb begin
        case (phase_reg)
            pcgb_pkg::PH_IDLE:  phase_next = start ? pcgb_pkg::PH_LOW : pcgb_pkg::PH_IDLE;
            pcgb_pkg::PH_LOW:   phase_next = pcgb_pkg::PH_MID_A;
            pcgb_pkg::PH_MID_A: phase_next = pcgb_pkg::PH_MID_B;
            default:            phase_next = pcgb_pkg::PH_IDLE;
        endcase
    end

    always_comb begin
        seed_next  = cfg.seed_we ? cfg.wdata : seed_reg;
        inc_next   = cfg.inc_we ? cfg.wdata : inc_reg;
        old_next   = (start && phase_reg == pcgb_pkg::PH_IDLE) ? state_reg : old_reg;
        state_next = state_reg;
        if (cfg.seed_we) begin
            state_next = cfg.wdata;
        end else if (phase_reg == pcgb_pkg::PH_MID_B) begin
            state_next = acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= pcgb_pkg::PH_IDLE;
            seed_reg  <= '0;
            inc_reg   <= '0;
            state_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            seed_reg  <= seed_next;
            inc_reg   <= inc_next;
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        old_reg <= old_next;
        acc_reg <= acc_next;
    end

    assign busy  = (phase_reg != pcgb_pkg::PH_IDLE);
    assign state = state_reg;
    assign seed  = seed_reg;
    assign incr  = inc_reg;

endmodule

`default_nettype wire

// ----- sv/pcgb_rem.sv -----
// pcgb_rem: radix-2 restoring remainder unit, one dividend bit per cycle
// with one shared subtract/compare; uses pcgb_pkg
`default_nettype none

module pcgb_rem (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             start,
    input  wire  [pcgb_pkg::DATA_W-1:0]     dividend,
    input  wire  [pcgb_pkg::DATA_W-1:0]     divisor,
    output logic                            busy,
    output logic [pcgb_pkg::DATA_W-1:0]     remainder
);

    logic                            run_reg, run_next;
    logic [pcgb_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [pcgb_pkg::DATA_W-1:0]     rem_reg, rem_next;
    logic [pcgb_pkg::DATA_W-1:0]     dvd_reg, dvd_next;
    logic [pcgb_pkg::DATA_W-1:0]     dsr_reg, dsr_next;
    logic [pcgb_pkg::DATA_W:0]       trial;
    logic [pcgb_pkg::DATA_W:0]       diff;
    logic                            fits;

    // zero divisor always fits, so the remainder ends up as the dividend
    assign trial = {rem_reg, dvd_reg[pcgb_pkg::DATA_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb begin
        run_next = run_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        dsr_next = dsr_reg;
        if (start && !run_reg) begin
            run_next = 1'b1;
            cnt_next = '1;
            rem_next = '0;
            dvd_next = dividend;
            dsr_next = divisor;
        end else if (run_reg) begin
            rem_next = fits ? diff[pcgb_pkg::DATA_W-1:0] : trial[pcgb_pkg::DATA_W-1:0];
            dvd_next = {dvd_reg[pcgb_pkg::DATA_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = run_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ----- sv/pcgb_ctrl.sv -----
// pcgb_ctrl: sequencer that starts the state advance and remainder units
// and hands the result to the output register; uses pcgb_pkg
`default_nettype none

module pcgb_ctrl (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       s_valid,
    input  wire                       out_valid,
    input  wire                       m_ready,
    input  wire pcgb_pkg::unit_status_t status,
    output logic                      s_ready,
    output pcgb_pkg::ctrl_cmd_t       cmd
);

    pcgb_pkg::ctrl_state_t state_reg, state_next;
    logic                  out_free;
    logic                  units_done;

    assign out_free   = !out_valid || m_ready;
    assign units_done = !status.div_busy && !status.lcg_busy;

    always_comb begin
        case (state_reg)
            pcgb_pkg::ST_IDLE: begin
                state_next = s_valid ? pcgb_pkg::ST_RUN : pcgb_pkg::ST_IDLE;
            end
            pcgb_pkg::ST_RUN: begin
                state_next = (units_done && out_free) ? pcgb_pkg::ST_IDLE : pcgb_pkg::ST_RUN;
            end
            default: begin
                state_next = pcgb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        case (state_reg)
            pcgb_pkg::ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.start    = s_valid;
                cmd.load_out = 1'b0;
            end
            pcgb_pkg::ST_RUN: begin
                s_ready      = 1'b0;
                cmd.start    = 1'b0;
                cmd.load_out = units_done && out_free;
            end
            default: begin
                s_ready      = 1'b0;
                cmd.start    = 1'b0;
                cmd.load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pcgb_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/pcg32_bounded_random.sv -----
// pcg32_bounded_random: an accepted input starts both units, then loads the output register
// one transaction at a time: s_ready stays low through the 32-step remainder loop
// the 64-bit state advance runs on one 32x32 multiplier alongside the remainder loop
// synchronous active-low reset clears seed, increment, state and output valid
// depends on pcgb_pkg, pcgb_lcg, pcgb_rem, pcgb_ctrl
`default_nettype none

module pcg32_bounded_random (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire  [pcgb_pkg::DATA_W-1:0]       s_bound,
    output logic                              m_valid,
    input  wire                               m_ready,
    output logic [pcgb_pkg::DATA_W-1:0]       m_value,
    output logic [pcgb_pkg::DATA_W-1:0]       m_raw,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [pcgb_pkg::ADDR_W-1:0]       paddr,
    input  wire  [pcgb_pkg::PDATA_W-1:0]      pwdata,
    output logic [pcgb_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    pcgb_pkg::cfg_wr_t               cfg;
    pcgb_pkg::unit_status_t          status;
    pcgb_pkg::ctrl_cmd_t             cmd;
    logic [pcgb_pkg::STATE_W-1:0]    gen_state;
    logic [pcgb_pkg::STATE_W-1:0]    seed;
    logic [pcgb_pkg::STATE_W-1:0]    incr;
    logic [pcgb_pkg::DATA_W-1:0]     raw_now;
    logic [pcgb_pkg::DATA_W-1:0]     remainder;
    logic                            wr_en;
    logic [pcgb_pkg::DATA_W-1:0]     raw_reg, raw_next;
    logic                            m_valid_reg, m_valid_next;
    logic [pcgb_pkg::DATA_W-1:0]     m_value_reg, m_value_next;
    logic [pcgb_pkg::DATA_W-1:0]     m_raw_reg, m_raw_next;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    assign cfg.seed_we = wr_en && (paddr[3] == pcgb_pkg::REG_SEED);
    assign cfg.inc_we  = wr_en && (paddr[3] == pcgb_pkg::REG_INC);
    assign cfg.wdata   = pwdata;

    assign prdata = (paddr[3] == pcgb_pkg::REG_INC) ? incr : seed;

    assign raw_now = pcgb_pkg::xsh_rr(gen_state);

    pcgb_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .out_valid (m_valid_reg),
        .m_ready   (m_ready),
        .status    (status),
        .s_ready   (s_ready),
        .cmd       (cmd)
    );

    pcgb_lcg u_lcg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .start   (cmd.start),
        .busy    (status.lcg_busy),
        .state   (gen_state),
        .seed    (seed),
        .incr    (incr)
    );

    pcgb_rem u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.start),
        .dividend  (raw_now),
        .divisor   (s_bound),
        .busy      (status.div_busy),
        .remainder (remainder)
    );

    always_comb begin
        raw_next     = cmd.start ? raw_now : raw_reg;
        m_value_next = cmd.load_out ? remainder : m_value_reg;
        m_raw_next   = cmd.load_out ? raw_reg : m_raw_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        raw_reg     <= raw_next;
        m_value_reg <= m_value_next;
        m_raw_reg   <= m_raw_next;
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;
    assign m_raw   = m_raw_reg;

endmodule

`default_nettype wire

// ----- sv/pcgb_checker.sv -----
// pcgb_checker: port-level assertions for pcg32_bounded_random and the
// bind that attaches them; uses pcgb_pkg for widths
`default_nettype none

module pcgb_checker (
    input wire                            aclk,
    input wire                            aresetn,
    input wire                            s_valid,
    input wire                            s_ready,
    input wire [pcgb_pkg::DATA_W-1:0]     s_bound,
    input wire                            m_valid,
    input wire                            m_ready,
    input wire [pcgb_pkg::DATA_W-1:0]     m_value,
    input wire [pcgb_pkg::DATA_W-1:0]     m_raw
);

    // one transaction in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("s_ready high right after an input transaction");

    // a result never shows up right after an accept
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !$rose(m_valid))
        else $error("result appeared one cycle after input transaction");

    // reduced value never exceeds the raw output
    a_value_le_raw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_value <= m_raw))
        else $error("m_value larger than m_raw");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_value) && $stable(m_raw)))
        else $error("stalled result changed");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("not idle after reset");

    logic unused_bound;
    assign unused_bound = ^s_bound;

endmodule

bind pcg32_bounded_random pcgb_checker u_pcgb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_bound (s_bound),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_value (m_value),
    .m_raw   (m_raw)
);

`default_nettype wire

// ----- dv/tb_pcg32_bounded_random.sv -----
// tb_pcg32_bounded_random: self-checking testbench for the pcg32 xsh-rr bounded generator
// drives bound requests, programs seed and increment over apb, predicts value and raw per draw
// depends on pcgb_pkg and pcg32_bounded_random
`default_nettype none

module tb_pcg32_bounded_random;

    localparam logic [63:0] PCG_MULT   = 64'd6364136223846793005;
    localparam logic [3:0]  ADDR_SEED  = 4'h0;
    localparam logic [3:0]  ADDR_INC   = 4'h8;
    localparam int unsigned DRAIN_WAIT = 40;
    localparam int unsigned CYCLE_MAX  = 1000000;

    typedef struct packed {
        logic [31:0] value;
        logic [31:0] raw;
    } draw_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    wire         s_ready;
    logic [31:0] s_bound = '0;
    wire         m_valid;
    logic        m_ready = 1'b0;
    wire  [31:0] m_value;
    wire  [31:0] m_raw;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    wire  [63:0] prdata;
    wire         pready;

    logic [31:0] pending_bounds [$];
    draw_t       expected_draws [$];
    logic [63:0] gen_state = '0;
    logic [63:0] inc_reg = '0;
    logic        in_taken = 1'b0;
    logic        quiet = 1'b0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned cycle_cnt = 0;
    int unsigned err_cnt = 0;

    logic [31:0] corner_bounds [0:19] = '{
        32'd1, 32'd2, 32'd3, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000,
        32'h7FFF_FFFF, 32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'd7, 32'd10,
        32'd100, 32'd1000, 32'h0001_0000, 32'h0000_FFFF, 32'h1234_5679, 32'd5, 32'd1
    };

    pcg32_bounded_random u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_bound (s_bound),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_value (m_value),
        .m_raw   (m_raw),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic logic [31:0] pcg_output(input logic [63:0] s);
        logic [63:0] mix_wide;
        logic [31:0] mixed;
        logic [5:0]  rot;
        mix_wide = ((s >> 18) ^ s) >> 27;
        mixed    = mix_wide[31:0];
        rot      = {1'b0, s[63:59]};
        return (mixed >> rot) | (mixed << (6'd32 - rot));
    endfunction

    function automatic draw_t next_draw(input logic [31:0] bound);
        draw_t d;
        d.raw   = pcg_output(gen_state);
        d.value = (bound != 32'd0) ? (d.raw % bound) : d.raw;
        gen_state = gen_state * PCG_MULT + (inc_reg | 64'd1);
        return d;
    endfunction

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [31:0] pick_bound();
        int unsigned r;
        int unsigned k;
        r = $urandom_range(99);
        k = $urandom_range(31);
        if (r < 40) return $urandom;
        if (r < 65) return $urandom_range(16, 1);
        if (r < 80) return (32'd1 << k) + $urandom_range(2) - 1;
        if (r < 90) return 32'hFFFF_FFFF - $urandom_range(15);
        return $urandom_range(65535, 1);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // input driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (gap_left > 0) begin
                s_valid  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_bounds.size() == 0) begin
                s_valid <= 1'b0;
            end else begin
                s_bound  <= pending_bounds.pop_front();
                s_valid  <= 1'b1;
                gap_left <= quiet ? 0 : idle_len();
            end
        end
    end

    // result backpressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready    <= 1'b1;
            stall_left <= quiet ? 0 : idle_len();
        end
    end

    // predictor and monitor
    always @(posedge aclk) begin
        draw_t want;
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_MAX) begin
            $display("Simulation FAILED");
            $finish;
        end else if (aresetn) begin
            in_taken = s_valid && s_ready;
            if (in_taken) begin
                expected_draws.push_back(next_draw(s_bound));
            end
            if (m_valid && m_ready) begin
                if (expected_draws.size() == 0) begin
                    $error("unexpected result transaction: value %0h raw %0h", m_value, m_raw);
                    err_cnt++;
                end else begin
                    want = expected_draws.pop_front();
                    if (m_value !== want.value) begin
                        $error("value mismatch: expected %0h actual %0h", want.value, m_value);
                        err_cnt++;
                    end
                    if (m_raw !== want.raw) begin
                        $error("raw mismatch: expected %0h actual %0h", want.raw, m_raw);
                        err_cnt++;
                    end
                end
            end
        end
    end

    task automatic apb_write(input logic [3:0] addr, input logic [63:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_SEED) begin
            gen_state = data;
        end else begin
            inc_reg = data;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check(input logic [3:0] addr, input logic [63:0] want);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want) begin
            $error("prdata mismatch at %0h: expected %0h actual %0h", addr, want, prdata);
            err_cnt++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic [63:0] seed_v, input logic [63:0] inc_v);
        apb_write(ADDR_SEED, seed_v);
        apb_write(ADDR_INC, inc_v);
        apb_read_check(ADDR_SEED, seed_v);
        apb_read_check(ADDR_INC, inc_v);
    endtask

    task automatic push_random(input int unsigned n);
        repeat (n) pending_bounds.push_back(pick_bound());
    endtask

    task automatic drain();
        while (pending_bounds.size() != 0 || s_valid || expected_draws.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    initial begin
        int i;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset state and increment, corner bounds
        foreach (corner_bounds[j]) pending_bounds.push_back(corner_bounds[j]);
        drain();

        set_config(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        quiet = 1'b1;
        push_random(120);
        drain();
        quiet = 1'b0;

        // sender holds off until everything is back
        set_config(64'd0, 64'd0);
        push_random(60);
        drain();
        push_random(60);
        drain();

        for (i = 0; i < 4; i++) begin
            set_config(rand64(), rand64());
            quiet = (i == 2);
            push_random(120);
            drain();
        end
        quiet = 1'b0;

        // increment change alone keeps the running state
        apb_write(ADDR_INC, rand64());
        apb_read_check(ADDR_INC, inc_reg);
        push_random(100);
        drain();

        set_config(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
        foreach (corner_bounds[j]) pending_bounds.push_back(corner_bounds[j]);
        push_random(100);
        drain();

        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
